// File: design/min_frequency_priority_queue_macros.svh
// Assertion macros for the min-frequency priority queue checker.
// No dependencies; included by the checker file only.
`ifndef MIN_FREQUENCY_PRIORITY_QUEUE_MACROS_SVH
`define MIN_FREQUENCY_PRIORITY_QUEUE_MACROS_SVH

// Property checked while out of reset.
`define MFPQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define MFPQ_ASSERT_ALL(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mfpq_pkg.sv
// Shared types and constants for the min-frequency priority queue.
// No dependencies; imported by every module of the block but mfpq_ram.
`default_nettype none

package mfpq_pkg;

  localparam int TAG_W      = 9;
  localparam int FREQ_W     = 32;
  localparam int CAP_W      = 9;
  localparam int CNT_OUT_W  = 9;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // in_tdata layout
  localparam int IN_TAG_LSB  = 0;
  localparam int IN_FREQ_LSB = IN_TAG_LSB + TAG_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // register index is paddr[2]
  localparam logic CFG_IDX_CAPACITY = 1'b0;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [FREQ_W-1:0] freq;
  } mfpq_entry_t;

  localparam int ENTRY_W = TAG_W + FREQ_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_X,
    S_RD_L,
    S_RD_R,
    S_CMP,
    S_PUT,
    S_NEXT,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_EXT_WR,
    S_FIN
  } mfpq_state_t;

  typedef struct packed {
    logic accept;    // take the input request
    logic rd_x;      // read the entry at the sift start
    logic rd_l;      // capture sifting entry, read left child
    logic rd_r;      // capture left child, read right child
    logic cmp;       // pick child, move it up or settle
    logic put;       // drop sifting entry into the hole
    logic next;      // step to the previous parent
    logic ext_root;  // read root
    logic ext_last;  // capture root, read last entry
    logic ext_wr;    // last entry to root, shrink count
    logic emit;      // load the output register
  } mfpq_cmd_t;

  typedef struct packed {
    logic op;
    logic nonempty;
    logic half_zero;
    logic start_one;
    logic swap;
    logic child_inner;
    logic out_free;
  } mfpq_stat_t;

endpackage

`default_nettype wire

// File: design/mfpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mfpq_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/mfpq_ctrl.sv
// Sequencer for the priority queue: request intake, heap rebuild, extract.
// Depends on mfpq_pkg.
`default_nettype none

module mfpq_ctrl import mfpq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire mfpq_stat_t stat,
  output mfpq_cmd_t       cmd
);

  mfpq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.op == OP_DEQUEUE && stat.nonempty) begin
            state_nxt = stat.half_zero ? S_EXT_ROOT : S_RD_X;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RD_X: begin
        cmd.rd_x  = 1'b1;
        state_nxt = S_RD_L;
      end
      S_RD_L: begin
        cmd.rd_l  = 1'b1;
        state_nxt = S_RD_R;
      end
      S_RD_R: begin
        cmd.rd_r  = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        // child read for the next level is issued in this cycle
        if (!stat.swap) begin
          state_nxt = S_NEXT;
        end else if (stat.child_inner) begin
          state_nxt = S_RD_R;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.next  = 1'b1;
        state_nxt = stat.start_one ? S_EXT_ROOT : S_RD_X;
      end
      S_EXT_ROOT: begin
        cmd.ext_root = 1'b1;
        state_nxt    = S_EXT_LAST;
      end
      S_EXT_LAST: begin
        cmd.ext_last = 1'b1;
        state_nxt    = S_EXT_WR;
      end
      S_EXT_WR: begin
        cmd.ext_wr = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/mfpq_datapath.sv
// Datapath: entry RAM, count, sift registers, child select and result register.
// Depends on mfpq_pkg and mfpq_ram.
`default_nettype none

module mfpq_datapath import mfpq_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mfpq_cmd_t             cmd,
  output mfpq_stat_t                 stat,
  input  wire logic [CAP_W-1:0]      cap,
  input  wire logic [0:0]            in_tuser,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]         count_r, start_r, pos_r;
  mfpq_entry_t           x_r, l_r, res_ent_r;
  logic                  res_ok_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  mfpq_entry_t           wdata, rdata, in_ent, cent;
  logic [ENTRY_W-1:0]    rdata_raw;

  logic [XW-1:0]         cap_x, max_x, eff_x, count_x;
  logic                  can_enq, full_now;
  logic [CW-1:0]         half, c_n;
  logic [CW:0]           pos2, c_idx, c2;
  logic                  has_right, take_right, swap;

  mfpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = mfpq_entry_t'(rdata_raw);

  assign in_ent.tag  = in_tdata[IN_TAG_LSB +: TAG_W];
  assign in_ent.freq = in_tdata[IN_FREQ_LSB +: FREQ_W];

  // capacity clamped to the store depth
  assign cap_x    = XW'(cap);
  assign max_x    = XW'(MAX_ENTRIES);
  assign eff_x    = (cap_x > max_x) ? max_x : cap_x;
  assign count_x  = XW'(count_r);
  assign can_enq  = count_x < eff_x;
  assign full_now = count_x >= eff_x;

  assign half = count_r >> 1;

  // child select: right only when present and strictly smaller
  assign pos2       = {pos_r, 1'b0};
  assign has_right  = pos2 < (CW + 1)'(count_r);
  assign take_right = has_right && (rdata.freq < l_r.freq);
  assign c_idx      = take_right ? pos2 + (CW + 1)'(1) : pos2;
  assign c_n        = CW'(c_idx);
  assign cent       = take_right ? rdata : l_r;
  assign swap       = x_r.freq > cent.freq;
  assign c2         = {c_n, 1'b0};

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = x_r;
    raddr = '0;
    if (cmd.accept && in_tuser[0] == OP_ENQUEUE && can_enq) begin
      we    = 1'b1;
      waddr = AW'(count_r);
      wdata = in_ent;
    end
    if (cmd.rd_x) begin
      raddr = AW'(start_r - CW'(1));
    end
    if (cmd.rd_l) begin
      raddr = AW'(pos2 - (CW + 1)'(1));
    end
    if (cmd.rd_r) begin
      raddr = AW'(pos2);
    end
    if (cmd.cmp) begin
      // hole moves down: parent slot takes the child, or the sifting entry settles
      we    = 1'b1;
      waddr = AW'(pos_r - CW'(1));
      wdata = swap ? cent : x_r;
      raddr = AW'(c2 - (CW + 1)'(1));
    end
    if (cmd.put) begin
      we    = 1'b1;
      waddr = AW'(pos_r - CW'(1));
      wdata = x_r;
    end
    if (cmd.ext_root) begin
      raddr = '0;
    end
    if (cmd.ext_last) begin
      raddr = AW'(count_r - CW'(1));
    end
    if (cmd.ext_wr) begin
      we    = 1'b1;
      waddr = '0;
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && in_tuser[0] == OP_ENQUEUE && can_enq) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.ext_wr) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_ok_r  <= (in_tuser[0] == OP_DEQUEUE) ? (count_r != '0) : can_enq;
      res_ent_r <= '0;
      start_r   <= half;
      pos_r     <= half;
    end
    if (cmd.rd_l) begin
      x_r <= rdata;
    end
    if (cmd.rd_r) begin
      l_r <= rdata;
    end
    if (cmd.cmp && swap) begin
      pos_r <= c_n;
    end
    if (cmd.next) begin
      start_r <= start_r - CW'(1);
      pos_r   <= start_r - CW'(1);
    end
    if (cmd.ext_last) begin
      res_ent_r <= rdata;
    end
    if (cmd.emit) begin
      out_data_r <= {3'b000, full_now, (count_r == '0), CNT_OUT_W'(count_r),
                     res_ent_r.freq, res_ent_r.tag, res_ok_r};
    end
  end

  assign stat.op          = in_tuser[0];
  assign stat.nonempty    = count_r != '0;
  assign stat.half_zero   = half == '0;
  assign stat.start_one   = start_r == CW'(1);
  assign stat.swap        = swap;
  assign stat.child_inner = c_idx <= (CW + 1)'(half);
  assign stat.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: design/min_frequency_priority_queue.sv
// Min-frequency priority queue top: capacity register, sequencer and datapath (mfpq_*).
// Enqueue or refused request: the result is loaded into the output register once it is free.
// Dequeue of n entries: n/2 sifts rebuild the heap, each moving the entry down level by level
// (one RAM read port); then the root is extracted and the last entry moved into its place.
// Next request is taken once the result sits in the output register.
// Synchronous active-low reset empties the queue and sets capacity to 256; no clearing pass.
`default_nettype none

module min_frequency_priority_queue import mfpq_pkg::*; #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [0] op
  input  wire logic [0:0]            in_tuser,
  // [8:0] item_tag, [40:9] frequency, [47:41] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] accepted, [9:1] out_tag, [41:10] out_frequency,
  // [50:42] entry_count_out, [51] is_empty, [52] is_full, [55:53] zero
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [CAP_W-1:0] cap_r;
  mfpq_cmd_t        cmd;
  mfpq_stat_t       stat;
  logic             cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[2] == CFG_IDX_CAPACITY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(cap_r) : '0;

  mfpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mfpq_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cap        (cap_r),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: design/mfpq_checker.sv
// Port-level checks on the result channel of the priority queue, bound to the top.
// Depends on mfpq_pkg and min_frequency_priority_queue_macros.svh.
`default_nettype none
`include "min_frequency_priority_queue_macros.svh"

module mfpq_checker import mfpq_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  `MFPQ_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `MFPQ_ASSERT(a_empty_flag, clk, rst_n, out_tvalid |-> (out_tdata[51] == (out_tdata[50:42] == 9'd0)), "empty flag disagrees with count")
  `MFPQ_ASSERT(a_refused_zero, clk, rst_n, out_tvalid && !out_tdata[0] |-> out_tdata[41:1] == 41'd0, "refused request carries an entry")
  `MFPQ_ASSERT_ALL(a_reset_idle, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind min_frequency_priority_queue mfpq_checker u_mfpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: sim/min_frequency_priority_queue_tb.sv
// Self-checking bench for the min-frequency priority queue: directed table, then random
// request mixes over several capacity settings, with a heap predictor held in the bench.
// Depends on mfpq_pkg and min_frequency_priority_queue.
`timescale 1ns / 100ps

module min_frequency_priority_queue_tb import mfpq_pkg::*;;

  localparam int          HEAP_DEPTH  = 256;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // result fields in out_tdata order, lowest bit last
  typedef struct packed {
    logic                 is_full;
    logic                 is_empty;
    logic [CNT_OUT_W-1:0] count;
    logic [FREQ_W-1:0]    freq;
    logic [TAG_W-1:0]     tag;
    logic                 accepted;
  } pq_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG}       row_kind_t;
  typedef enum logic {CHK_PREDICT, CHK_TYPED}  row_check_t;
  typedef enum logic [1:0] {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              op;
    logic [TAG_W-1:0]  tag;
    logic [FREQ_W-1:0] freq;   // capacity value on ROW_CFG rows
    row_check_t        chk;
    pq_result_t        want;
  } stim_row_t;

  localparam pq_result_t NO_RESULT = '0;

  // columns of want: full, empty, count, freq, tag, accepted
  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_TYPED,
      '{1'b0, 1'b1, 9'd0, 32'd0, 9'd0, 1'b0}},
    '{ROW_ITEM, OP_ENQUEUE, 9'd511, 32'hFFFF_FFFF, CHK_TYPED,
      '{1'b0, 1'b0, 9'd1, 32'd0, 9'd0, 1'b1}},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_TYPED,
      '{1'b0, 1'b1, 9'd0, 32'hFFFF_FFFF, 9'd511, 1'b1}},
    '{ROW_ITEM, OP_ENQUEUE, 9'd0,   32'd0,         CHK_TYPED,
      '{1'b0, 1'b0, 9'd1, 32'd0, 9'd0, 1'b1}},
    '{ROW_ITEM, OP_ENQUEUE, 9'h155, 32'hAAAA_AAAA, CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'h0AA, 32'h5555_5555, CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'd7,   32'd0,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'd8,   32'd9,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'd9,   32'd9,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'd10,  32'hFFFF_FFFE, CHK_PREDICT, NO_RESULT},
    // capacity dropped below the count held
    '{ROW_CFG,  OP_ENQUEUE, 9'd0,   32'd2,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'd11,  32'd1,         CHK_TYPED,
      '{1'b1, 1'b0, 9'd7, 32'd0, 9'd0, 1'b0}},
    '{ROW_ITEM, OP_DEQUEUE, 9'd300, 32'd12345,     CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_DEQUEUE, 9'd300, 32'd12345,     CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_PREDICT, NO_RESULT},
    // zero capacity: empty and full at once
    '{ROW_CFG,  OP_ENQUEUE, 9'd0,   32'd0,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'd12,  32'd3,         CHK_TYPED,
      '{1'b1, 1'b1, 9'd0, 32'd0, 9'd0, 1'b0}},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_TYPED,
      '{1'b1, 1'b1, 9'd0, 32'd0, 9'd0, 1'b0}},
    '{ROW_CFG,  OP_ENQUEUE, 9'd0,   32'd1,         CHK_PREDICT, NO_RESULT},
    '{ROW_ITEM, OP_ENQUEUE, 9'h1FF, 32'd0,         CHK_TYPED,
      '{1'b1, 1'b0, 9'd1, 32'd0, 9'd0, 1'b1}},
    '{ROW_ITEM, OP_ENQUEUE, 9'd13,  32'd5,         CHK_TYPED,
      '{1'b1, 1'b0, 9'd1, 32'd0, 9'd0, 1'b0}},
    '{ROW_ITEM, OP_DEQUEUE, 9'd0,   32'd0,         CHK_TYPED,
      '{1'b0, 1'b1, 9'd0, 32'd0, 9'h1FF, 1'b1}}
  };

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [0:0]            in_tuser    = '0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  min_frequency_priority_queue i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // bench copy of the queue state
  mfpq_entry_t      heap_mem [HEAP_DEPTH];
  int unsigned      heap_count   = 0;
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;

  pq_result_t  pending_results [$];
  pace_t       pace          = PACE_SLOW_RX;
  int          sent_total    = 0;
  int          mismatch_count = 0;
  int          refused_requests = 0;
  int unsigned cycle_count   = 0;
  int          hold_req      = 0;
  int          hold_done     = 0;
  int          hold_left     = 0;

  function automatic void sink_entry(int unsigned start, int unsigned last);
    int unsigned p;
    int unsigned c;
    mfpq_entry_t t;
    p = start;
    while (p <= last / 2) begin
      c = 2 * p;
      if (c + 1 <= last && heap_mem[c].freq < heap_mem[c-1].freq) c = c + 1;
      if (heap_mem[p-1].freq > heap_mem[c-1].freq) begin
        t            = heap_mem[p-1];
        heap_mem[p-1] = heap_mem[c-1];
        heap_mem[c-1] = t;
        p            = c;
      end else begin
        return;
      end
    end
  endfunction

  // applies one request to the bench state and returns what the block should report
  function automatic pq_result_t next_heap_result(logic op, logic [TAG_W-1:0] tag,
                                                  logic [FREQ_W-1:0] freq);
    pq_result_t  r;
    int unsigned limit_now;
    int          p;
    mfpq_entry_t t;
    r         = '0;
    limit_now = (capacity_reg > HEAP_DEPTH) ? HEAP_DEPTH : capacity_reg;
    if (op == OP_ENQUEUE) begin
      if (heap_count < limit_now) begin
        heap_mem[heap_count] = '{tag: tag, freq: freq};
        heap_count++;
        r.accepted = 1'b1;
      end
    end else if (heap_count > 0) begin
      for (p = heap_count / 2; p >= 1; p--) sink_entry(p, heap_count);
      t                      = heap_mem[0];
      heap_mem[0]            = heap_mem[heap_count-1];
      heap_mem[heap_count-1] = t;
      heap_count--;
      r.tag      = heap_mem[heap_count].tag;
      r.freq     = heap_mem[heap_count].freq;
      r.accepted = 1'b1;
    end
    r.count    = heap_count[CNT_OUT_W-1:0];
    r.is_empty = (heap_count == 0);
    r.is_full  = (heap_count >= limit_now);
    return r;
  endfunction

  // ties are made likely so that the strict comparisons get exercised
  function automatic logic [FREQ_W-1:0] rand_frequency();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(7);
      5:       return $urandom_range(255);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_request(input logic op, input logic [TAG_W-1:0] tag,
                              input logic [FREQ_W-1:0] freq,
                              input logic use_typed, input pq_result_t typed_want);
    pq_result_t predicted;
    pace = (sent_total < 170) ? PACE_SLOW_RX : (sent_total < 340) ? PACE_SLOW_TX : PACE_FULL;
    while ((pace == PACE_SLOW_RX && $urandom_range(99) < 18) ||
           (pace == PACE_SLOW_TX && $urandom_range(99) < 80)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, freq, tag};
    do @(posedge clk); while (!in_tready);
    // bench state follows every request, typed rows included
    predicted = next_heap_result(op, tag, freq);
    pending_results.push_back(use_typed ? typed_want : predicted);
    sent_total++;
  endtask

  task automatic wait_queue_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_queue_idle();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {CFG_IDX_CAPACITY, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic run_mix(input logic [CAP_W-1:0] cap, input int n, input int enq_pct,
                         input int hold_at);
    write_capacity(cap);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_req <= hold_req + 1;
      push_request(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                   $urandom_range(511), rand_frequency(), 1'b0, NO_RESULT);
    end
  endtask

  // receiver: random stalls per pace, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      out_tready <= 1'b0;
      hold_done  <= hold_req;
      hold_left  <= HOLD_CYCLES;
    end else begin
      case (pace)
        PACE_SLOW_RX: out_tready <= ($urandom_range(99) >= 80);
        PACE_SLOW_TX: out_tready <= ($urandom_range(99) >= 18);
        default:      out_tready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pq_result_t got;
    pq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(pq_result_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted",        want.accepted, got.accepted);
        check_field("out_tag",         want.tag,      got.tag);
        check_field("out_frequency",   want.freq,     got.freq);
        check_field("entry_count_out", want.count,    got.count);
        check_field("is_empty",        want.is_empty, got.is_empty);
        check_field("is_full",         want.is_full,  got.is_full);
        if (!want.accepted) refused_requests++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG)
        write_capacity(DIRECTED_ROWS[i].freq[CAP_W-1:0]);
      else
        push_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].tag, DIRECTED_ROWS[i].freq,
                     DIRECTED_ROWS[i].chk == CHK_TYPED, DIRECTED_ROWS[i].want);
    end

    run_mix(9'd8,   30, 55, -1);
    run_mix(9'd1,   25, 50, -1);
    run_mix(9'd256, 50, 65, 20);  // long receiver hold-off part way through
    run_mix(9'd4,   35, 30, -1);  // starts above capacity, drains
    run_mix(9'd0,   15, 50, -1);

    // over-range capacity clamps to the store depth: fill it, bounce off, then extract
    write_capacity(9'd511);
    while (heap_count < HEAP_DEPTH)
      push_request(OP_ENQUEUE, $urandom_range(511), rand_frequency(), 1'b0, NO_RESULT);
    repeat (3) push_request(OP_ENQUEUE, $urandom_range(511), rand_frequency(), 1'b0, NO_RESULT);
    repeat (20) push_request(OP_DEQUEUE, $urandom_range(511), $urandom(), 1'b0, NO_RESULT);

    wait_queue_idle();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests (%0d refused) across capacities 0 to 511,",
             sent_total, refused_requests);
    $display("including a full 256-entry heap and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
